### hw/rtl/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// sbsm_pkg
// Shared types and constants for the sub-pixel bilinear SAD matcher.
// ----------------------------------------------------------------------------
package sbsm_pkg;

	// Width of a motion vector component in quarter-pel units.
	localparam int VEC_BITS   = 11;
	// Width of the vector cost field.
	localparam int VCOST_BITS = 16;
	// Fractional bits of a vector component that select the bilinear weights.
	localparam int FRAC_BITS  = 2;
	// Weight of a full sample along one axis (the four corner weights sum to 16).
	localparam int WEIGHT_ONE = 4;
	// Rounding offset and shift applied to the weighted sum.
	localparam int ROUND_BIAS = 8;
	localparam int ROUND_SHIFT = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INTERP,
		ST_ACCUM,
		ST_UPDATE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic interp;
		logic accum;
		logic update;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
	} stat_t;

endpackage

### hw/rtl/sbsm_pix_if.sv
// ----------------------------------------------------------------------------
// sbsm_pix_if
// Pixel channel: one candidate pixel with its reference corners and vector.
// ----------------------------------------------------------------------------
interface sbsm_pix_if #(
	parameter int PIXEL_BITS = 10
);
	logic                                  valid;
	logic                                  ready;
	logic [PIXEL_BITS-1:0]                 cur_pixel;
	logic [PIXEL_BITS-1:0]                 ref_top_left;
	logic [PIXEL_BITS-1:0]                 ref_top_right;
	logic [PIXEL_BITS-1:0]                 ref_bottom_left;
	logic [PIXEL_BITS-1:0]                 ref_bottom_right;
	logic signed [sbsm_pkg::VEC_BITS-1:0]  vec_x;
	logic signed [sbsm_pkg::VEC_BITS-1:0]  vec_y;
	logic [sbsm_pkg::VCOST_BITS-1:0]       vec_cost;
	logic                                  first_pixel;
	logic                                  last_pixel;
	logic                                  new_block;

	modport source (
		output valid, cur_pixel, ref_top_left, ref_top_right, ref_bottom_left,
			ref_bottom_right, vec_x, vec_y, vec_cost, first_pixel, last_pixel,
			new_block,
		input  ready
	);

	modport sink (
		input  valid, cur_pixel, ref_top_left, ref_top_right, ref_bottom_left,
			ref_bottom_right, vec_x, vec_y, vec_cost, first_pixel, last_pixel,
			new_block,
		output ready
	);
endinterface

### hw/rtl/sbsm_res_if.sv
// ----------------------------------------------------------------------------
// sbsm_res_if
// Result channel: candidate total and the best match found so far.
// ----------------------------------------------------------------------------
interface sbsm_res_if #(
	parameter int COST_BITS = 24
);
	logic                                  valid;
	logic                                  ready;
	logic [COST_BITS-1:0]                  cand_total;
	logic                                  improved;
	logic [COST_BITS-1:0]                  best_total_out;
	logic [COST_BITS-1:0]                  best_sad_out;
	logic signed [sbsm_pkg::VEC_BITS-1:0]  best_vec_x;
	logic signed [sbsm_pkg::VEC_BITS-1:0]  best_vec_y;

	modport source (
		output valid, cand_total, improved, best_total_out, best_sad_out,
			best_vec_x, best_vec_y,
		input  ready
	);

	modport sink (
		input  valid, cand_total, improved, best_total_out, best_sad_out,
			best_vec_x, best_vec_y,
		output ready
	);
endinterface

### hw/rtl/sbsm_ctrl.sv
// ----------------------------------------------------------------------------
// sbsm_ctrl
// Sequencer: accept, interpolate, accumulate, and compare on the last pixel.
// ----------------------------------------------------------------------------
module sbsm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  sbsm_pkg::stat_t stat,
	output sbsm_pkg::cmd_t  cmd
);

	sbsm_pkg::state_t state_q;
	sbsm_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_free;

	// The output register can take a new result when empty or draining now.
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbsm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			sbsm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = sbsm_pkg::ST_INTERP;
				end
			end
			sbsm_pkg::ST_INTERP: begin
				cmd.interp = 1'b1;
				state_d    = sbsm_pkg::ST_ACCUM;
			end
			sbsm_pkg::ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = stat.last ? sbsm_pkg::ST_UPDATE : sbsm_pkg::ST_IDLE;
			end
			sbsm_pkg::ST_UPDATE: begin
				if (out_free) begin
					cmd.update = 1'b1;
					state_d    = sbsm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sbsm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/sbsm_dp.sv
// ----------------------------------------------------------------------------
// sbsm_dp
// Datapath: bilinear interpolation, saturating SAD sum and best-match store.
// ----------------------------------------------------------------------------
module sbsm_dp #(
	parameter int PIXEL_BITS = 10,
	parameter int COST_BITS  = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sbsm_pkg::cmd_t                       cmd,
	output sbsm_pkg::stat_t                      stat,
	input  logic [PIXEL_BITS-1:0]                cur_pixel,
	input  logic [PIXEL_BITS-1:0]                ref_top_left,
	input  logic [PIXEL_BITS-1:0]                ref_top_right,
	input  logic [PIXEL_BITS-1:0]                ref_bottom_left,
	input  logic [PIXEL_BITS-1:0]                ref_bottom_right,
	input  logic signed [sbsm_pkg::VEC_BITS-1:0] vec_x,
	input  logic signed [sbsm_pkg::VEC_BITS-1:0] vec_y,
	input  logic [sbsm_pkg::VCOST_BITS-1:0]      vec_cost,
	input  logic                                 first_pixel,
	input  logic                                 last_pixel,
	input  logic                                 new_block,
	output logic [COST_BITS-1:0]                 cand_total,
	output logic                                 improved,
	output logic [COST_BITS-1:0]                 best_total_out,
	output logic [COST_BITS-1:0]                 best_sad_out,
	output logic signed [sbsm_pkg::VEC_BITS-1:0] best_vec_x,
	output logic signed [sbsm_pkg::VEC_BITS-1:0] best_vec_y
);

	localparam int ACC_W = PIXEL_BITS + 6;
	localparam int W_W   = 5;
	localparam int WA_W  = 3;

	// Captured transaction.
	logic [PIXEL_BITS-1:0]                cur_q, tl_q, tr_q, bl_q, br_q;
	logic signed [sbsm_pkg::VEC_BITS-1:0] vx_q, vy_q;
	logic [sbsm_pkg::VCOST_BITS-1:0]      vcost_q;
	logic                                 first_q, last_q, newblk_q;

	logic [PIXEL_BITS-1:0]                pred_q;

	// Architectural state.
	logic [COST_BITS-1:0]                 running_sum_q;
	logic [COST_BITS-1:0]                 best_total_q;
	logic [COST_BITS-1:0]                 best_sad_q;
	logic signed [sbsm_pkg::VEC_BITS-1:0] best_x_q, best_y_q;

	// Output register.
	logic [COST_BITS-1:0]                 cand_total_q, best_total_out_q, best_sad_out_q;
	logic                                 improved_q;
	logic signed [sbsm_pkg::VEC_BITS-1:0] best_vec_x_q, best_vec_y_q;

	logic [sbsm_pkg::FRAC_BITS-1:0] rx, ry;
	logic [WA_W-1:0]                wx0, wx1, wy0, wy1;
	logic [W_W-1:0]                 w_tl, w_tr, w_bl, w_br;
	logic [ACC_W-1:0]               acc;
	logic [PIXEL_BITS-1:0]          pred;
	logic [PIXEL_BITS-1:0]          diff;
	logic [COST_BITS-1:0]           vcost_ext;
	logic [COST_BITS-1:0]           base;
	logic [COST_BITS:0]             sum_ext;
	logic [COST_BITS-1:0]           sum_sat;
	logic                           better;
	logic [COST_BITS-1:0]           sad;

	assign stat.last = last_q;

	// Bilinear weights from the fractional vector bits.
	always_comb begin
		rx   = vx_q[sbsm_pkg::FRAC_BITS-1:0];
		ry   = vy_q[sbsm_pkg::FRAC_BITS-1:0];
		wx1  = WA_W'(rx);
		wy1  = WA_W'(ry);
		wx0  = WA_W'(sbsm_pkg::WEIGHT_ONE) - wx1;
		wy0  = WA_W'(sbsm_pkg::WEIGHT_ONE) - wy1;
		w_tl = W_W'(wx0) * W_W'(wy0);
		w_tr = W_W'(wx1) * W_W'(wy0);
		w_bl = W_W'(wx0) * W_W'(wy1);
		w_br = W_W'(wx1) * W_W'(wy1);
		acc  = ACC_W'(w_tl) * ACC_W'(tl_q) + ACC_W'(w_tr) * ACC_W'(tr_q)
			+ ACC_W'(w_bl) * ACC_W'(bl_q) + ACC_W'(w_br) * ACC_W'(br_q)
			+ ACC_W'(sbsm_pkg::ROUND_BIAS);
		pred = acc[sbsm_pkg::ROUND_SHIFT +: PIXEL_BITS];
	end

	// Absolute difference and saturating accumulation.
	always_comb begin
		diff      = (cur_q >= pred_q) ? (cur_q - pred_q) : (pred_q - cur_q);
		vcost_ext = COST_BITS'(vcost_q);
		base      = first_q ? vcost_ext : running_sum_q;
		sum_ext   = {1'b0, base} + (COST_BITS + 1)'(diff);
		sum_sat   = sum_ext[COST_BITS] ? {COST_BITS{1'b1}} : sum_ext[COST_BITS-1:0];
	end

	// Best-match compare on the finished candidate total.
	always_comb begin
		better = running_sum_q < best_total_q;
		sad    = (running_sum_q >= vcost_ext) ? (running_sum_q - vcost_ext) : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q    <= cur_pixel;
			tl_q     <= ref_top_left;
			tr_q     <= ref_top_right;
			bl_q     <= ref_bottom_left;
			br_q     <= ref_bottom_right;
			vx_q     <= vec_x;
			vy_q     <= vec_y;
			vcost_q  <= vec_cost;
			first_q  <= first_pixel;
			newblk_q <= new_block;
		end
		if (cmd.interp) begin
			pred_q <= pred;
		end
		if (cmd.update) begin
			cand_total_q     <= running_sum_q;
			improved_q       <= better;
			best_total_out_q <= better ? running_sum_q : best_total_q;
			best_sad_out_q   <= better ? sad : best_sad_q;
			best_vec_x_q     <= better ? vx_q : best_x_q;
			best_vec_y_q     <= better ? vy_q : best_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q        <= 1'b0;
			running_sum_q <= '0;
			best_total_q  <= '1;
			best_sad_q    <= '0;
			best_x_q      <= '0;
			best_y_q      <= '0;
		end else begin
			if (cmd.load_in) begin
				last_q <= last_pixel;
			end
			if (cmd.accum) begin
				running_sum_q <= sum_sat;
				if (first_q && newblk_q) begin
					best_total_q <= '1;
				end
			end
			if (cmd.update && better) begin
				best_total_q <= running_sum_q;
				best_sad_q   <= sad;
				best_x_q     <= vx_q;
				best_y_q     <= vy_q;
			end
		end
	end

	assign cand_total     = cand_total_q;
	assign improved       = improved_q;
	assign best_total_out = best_total_out_q;
	assign best_sad_out   = best_sad_out_q;
	assign best_vec_x     = best_vec_x_q;
	assign best_vec_y     = best_vec_y_q;

endmodule

### hw/rtl/subpel_bilinear_sad_match_top.sv
// ----------------------------------------------------------------------------
// subpel_bilinear_sad_match_top
// Scores motion-vector candidates with a sub-pixel bilinear SAD.
// ----------------------------------------------------------------------------
// Each transaction on the pixel channel carries one pixel of a candidate block:
// the current sample, four up-converted reference samples around it, the
// candidate vector in quarter-pel units and its vector cost. The two low bits of
// each vector component weight the four corners bilinearly, and the weighted
// sum is rounded with plus eight and a shift by four. The absolute difference
// to the current sample is added to a running sum that starts at the vector
// cost on a first pixel and saturates at the top of the cost range. A last
// pixel produces one result transaction with the candidate total and the best
// match so far; a total strictly below the stored best replaces the best total,
// SAD and vector, and a new-block flag on a first pixel clears the best total
// to maximum. The sequencer steps through capture, interpolation,
// accumulation and, on a last pixel, the best-match compare, one step a cycle,
// and accepts the next pixel only after the last of these steps. The result
// sits in an output register, so the block takes new pixels while a result
// waits; only a following last pixel waits at its compare step until that
// register has been taken.
// ----------------------------------------------------------------------------
module subpel_bilinear_sad_match_top #(
	parameter int PIXEL_BITS = 10,
	parameter int COST_BITS  = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	sbsm_pix_if.sink   pixel,
	sbsm_res_if.source result
);

	sbsm_pkg::cmd_t  cmd;
	sbsm_pkg::stat_t stat;

	// The sequencer owns the handshakes and the output valid flag.
	sbsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the captured pixel, the running sum and the best match.
	sbsm_dp #(
		.PIXEL_BITS (PIXEL_BITS),
		.COST_BITS  (COST_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cur_pixel        (pixel.cur_pixel),
		.ref_top_left     (pixel.ref_top_left),
		.ref_top_right    (pixel.ref_top_right),
		.ref_bottom_left  (pixel.ref_bottom_left),
		.ref_bottom_right (pixel.ref_bottom_right),
		.vec_x            (pixel.vec_x),
		.vec_y            (pixel.vec_y),
		.vec_cost         (pixel.vec_cost),
		.first_pixel      (pixel.first_pixel),
		.last_pixel       (pixel.last_pixel),
		.new_block        (pixel.new_block),
		.cand_total       (result.cand_total),
		.improved         (result.improved),
		.best_total_out   (result.best_total_out),
		.best_sad_out     (result.best_sad_out),
		.best_vec_x       (result.best_vec_x),
		.best_vec_y       (result.best_vec_y)
	);

	// A new result may only be written when the output register is free.
	a_update_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (!result.valid || result.ready))
		else $error("result overwritten while still pending");

	// The output valid flag only rises right after a compare step.
	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.update))
		else $error("result presented without a compare step");

	// An improved candidate becomes the best total.
	a_improved_best: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.improved) |-> (result.cand_total == result.best_total_out))
		else $error("improved candidate not taken as best");

	// The best total never exceeds the candidate just scored.
	a_best_le_cand: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.best_total_out <= result.cand_total))
		else $error("best total above candidate total");

endmodule
